// ----- rtl/core/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte-level functions of the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int NumRounds = 10;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef struct packed {
    logic         op;
    logic [127:0] st;
    logic [127:0] rk;
  } cell_data_t;

  localparam logic [7:0] FWD_SUB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SUB [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of a 128-bit word, byte 0 in the top bits
  function automatic logic [7:0] get_b(input logic [127:0] w, input int i);
    return w[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [7:0] b [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = get_b(k, i);
    b[0] = b[0] ^ FWD_SUB[b[13]] ^ rc;
    b[1] = b[1] ^ FWD_SUB[b[14]];
    b[2] = b[2] ^ FWD_SUB[b[15]];
    b[3] = b[3] ^ FWD_SUB[b[12]];
    for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i-4];
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = b[i];
    return o;
  endfunction

  function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
    logic [7:0] b [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = get_b(k, i);
    for (int i = 15; i > 3; i--) b[i] = b[i] ^ b[i-4];
    b[0] = b[0] ^ FWD_SUB[b[13]] ^ rc;
    b[1] = b[1] ^ FWD_SUB[b[14]];
    b[2] = b[2] ^ FWD_SUB[b[15]];
    b[3] = b[3] ^ FWD_SUB[b[12]];
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = b[i];
    return o;
  endfunction

  // dir 1: forward shift rows, dir 3: inverse
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input int dir);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = get_b(s, 4*((c + r*dir) & 3) + r);
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [7:0] a0, a1, a2, a3, t;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c);
      a1 = get_b(s, 4*c+1);
      a2 = get_b(s, 4*c+2);
      a3 = get_b(s, 4*c+3);
      t  = a0 ^ a1 ^ a2 ^ a3;
      o[127-8*(4*c)   -: 8] = a0 ^ t ^ xtime(a0 ^ a1);
      o[127-8*(4*c+1) -: 8] = a1 ^ t ^ xtime(a1 ^ a2);
      o[127-8*(4*c+2) -: 8] = a2 ^ t ^ xtime(a2 ^ a3);
      o[127-8*(4*c+3) -: 8] = a3 ^ t ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

  function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
    logic [7:0] u, v;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      u = xtime(xtime(get_b(s, 4*c) ^ get_b(s, 4*c+2)));
      v = xtime(xtime(get_b(s, 4*c+1) ^ get_b(s, 4*c+3)));
      o[127-8*(4*c)   -: 8] = get_b(s, 4*c)   ^ u;
      o[127-8*(4*c+1) -: 8] = get_b(s, 4*c+1) ^ v;
      o[127-8*(4*c+2) -: 8] = get_b(s, 4*c+2) ^ u;
      o[127-8*(4*c+3) -: 8] = get_b(s, 4*c+3) ^ v;
    end
    return mix_cols(o);
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++)
      o[127-8*i -: 8] = inv ? INV_SUB[get_b(s, i)] : FWD_SUB[get_b(s, i)];
    return o;
  endfunction

endpackage

// ----- rtl/core/aes_key_cell.sv -----
// ----------------------------------------------------------------------------
// aes_key_cell
// One key-prep stage: walks the key forward one round for decrypt items so
// the last round key is ready at the round chain. Encrypt keys pass through.
// ----------------------------------------------------------------------------
module aes_key_cell
  import aes_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vld_i,
  input  cell_data_t dat_i,
  output logic       vld_o,
  output cell_data_t dat_o
);

  logic       vld_r;
  cell_data_t dat_r;
  cell_data_t dat_nxt;

  always_comb begin
    dat_nxt = dat_i;
    if (dat_i.op == OP_DEC) begin
      dat_nxt.rk = key_fwd(dat_i.rk, RCON[Idx]);
      if (Idx == NumRounds - 1) dat_nxt.st = dat_i.st ^ dat_nxt.rk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

// ----- rtl/core/aes_round_cell.sv -----
// ----------------------------------------------------------------------------
// aes_round_cell
// One cipher round stage for either direction, with on-the-fly round key.
// ----------------------------------------------------------------------------
module aes_round_cell
  import aes_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vld_i,
  input  cell_data_t dat_i,
  output logic       vld_o,
  output cell_data_t dat_o
);

  logic       vld_r;
  cell_data_t dat_r;
  cell_data_t dat_nxt;
  logic [127:0] s, kn;

  always_comb begin
    dat_nxt = dat_i;
    s  = '0;
    kn = '0;
    if (dat_i.op == OP_ENC) begin
      s = shift_rows(sub_bytes(dat_i.st ^ dat_i.rk, 1'b0), 1);
      if (Idx < NumRounds - 1) s = mix_cols(s);
      kn = key_fwd(dat_i.rk, RCON[Idx]);
      if (Idx == NumRounds - 1) s = s ^ kn;
    end else begin
      kn = key_bwd(dat_i.rk, RCON[NumRounds - 1 - Idx]);
      s  = dat_i.st;
      if (Idx > 0) s = inv_mix_cols(s);
      s = sub_bytes(shift_rows(s, 3), 1'b1) ^ kn;
    end
    dat_nxt.st = s;
    dat_nxt.rk = kn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

// ----- rtl/core/aes128_block_cipher_top.sv -----
// ----------------------------------------------------------------------------
// aes128_block_cipher_top
// AES-128 encrypt/decrypt as a chain of 10 key-prep and 10 round cells.
// ----------------------------------------------------------------------------
// Each block passes through the key-prep cells, then the round cells, to the output.
// Throughput: one block per cycle; the chain advances as one pipeline and
// stalls as a whole when the result is not taken.
// Reset clears valid flags and both key registers to zero.
module aes128_block_cipher_top
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int NumCells = 2 * NumRounds;

  logic [63:0] key_high_r, key_low_r;
  logic       en;
  logic       vld [NumCells+1];
  cell_data_t dat [NumCells+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !vld[NumCells] || out_ready;
  assign in_ready = en;

  assign vld[0]    = in_valid;
  assign dat[0].op = in_data.op;
  assign dat[0].st = {in_data.block_high, in_data.block_low};
  assign dat[0].rk = {key_high_r, key_low_r};

  for (genvar g = 0; g < NumRounds; g++) begin : g_key
    aes_key_cell #(.Idx(g)) u_key (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(vld[g]), .dat_i(dat[g]),
      .vld_o(vld[g+1]), .dat_o(dat[g+1])
    );
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    aes_round_cell #(.Idx(g)) u_rnd (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(vld[NumRounds+g]), .dat_i(dat[NumRounds+g]),
      .vld_o(vld[NumRounds+g+1]), .dat_o(dat[NumRounds+g+1])
    );
  end

  assign out_valid            = vld[NumCells];
  assign out_data.result_high = dat[NumCells].st[127:64];
  assign out_data.result_low  = dat[NumCells].st[63:0];

endmodule
